### sv/dmac_pkg.sv
`timescale 1ns / 1ps

package dmac_pkg;

   localparam int ACC_COUNT       = 4;
   localparam int ACC_INDEX_WIDTH = $clog2(ACC_COUNT);
   localparam int ACC_WIDTH       = 40;
   localparam int OPERAND_WIDTH   = 16;
   localparam int MUL_WIDTH       = OPERAND_WIDTH + 1;
   localparam int PRODUCT_WIDTH   = 2 * MUL_WIDTH;
   localparam int SUM_WIDTH       = ACC_WIDTH + 2;
   localparam int HALF_SHIFT      = 16;
   localparam int SEL_WIDTH       = 3;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 1;

   localparam logic [HALF_SHIFT-1:0] ROUND_HALF = 16'h8000;

   localparam logic signed [SUM_WIDTH-1:0] LIMIT_HI_WIDE   = 42'sh7F_FFFF_FFFF;
   localparam logic signed [SUM_WIDTH-1:0] LIMIT_LO_WIDE   = -42'sh80_0000_0000;
   localparam logic signed [SUM_WIDTH-1:0] LIMIT_HI_NARROW = 42'sh7FFF_FFFF;
   localparam logic signed [SUM_WIDTH-1:0] LIMIT_LO_NARROW = -42'sh8000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRACTIONAL_MODE  = 3'd0,
      CSR_CONVERGENT_ROUND = 3'd1,
      CSR_LEGACY_COMPAT    = 3'd2,
      CSR_OVERFLOW_DETECT  = 3'd3,
      CSR_SATURATE_ENABLE  = 3'd4,
      CSR_WIDE_MODE        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic fractional_mode;
      logic convergent_round;
      logic legacy_compat;
      logic overflow_detect;
      logic saturate_enable;
      logic wide_mode;
   } csr_type;

   typedef struct packed {
      logic [SEL_WIDTH-1:0]       x_select;
      logic [OPERAND_WIDTH-1:0]   x_operand;
      logic [SEL_WIDTH-1:0]       y_select;
      logic [OPERAND_WIDTH-1:0]   y_operand;
      logic [SEL_WIDTH-1:0]       acc_select;
      logic [ACC_INDEX_WIDTH-1:0] dest_select;
      logic                       unsigned_x;
      logic                       unsigned_y;
      logic                       subtract_mode;
      logic                       force_wide;
      logic                       round_enable;
      logic                       shift_accumulator;
   } req_fields_type;

endpackage

### sv/dsp_multiply_accumulate_unit_top.sv
`timescale 1ns / 1ps

// Multiply-accumulate unit with four 40-bit accumulators and sticky overflow flags.
// A transaction is registered on acceptance and its result is registered when that
// stage advances, which waits while a result is held unread. One request is taken
// every cycle as long as results are drained. The accumulator file is written
// in the result stage, so each transaction sees the accumulators left by the one before
// it. The single 17x17 multiply, the 42-bit add and the limit compare sit in that one
// stage and set its timing. Write the control registers only while no transaction is
// in flight.
module dsp_multiply_accumulate_unit_top
   import dmac_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [SEL_WIDTH-1:0]        req_x_select,
   input  logic [OPERAND_WIDTH-1:0]    req_x_operand,
   input  logic [SEL_WIDTH-1:0]        req_y_select,
   input  logic [OPERAND_WIDTH-1:0]    req_y_operand,
   input  logic [SEL_WIDTH-1:0]        req_acc_select,
   input  logic [ACC_INDEX_WIDTH-1:0]  req_dest_select,
   input  logic                        req_unsigned_x,
   input  logic                        req_unsigned_y,
   input  logic                        req_subtract_mode,
   input  logic                        req_force_wide,
   input  logic                        req_round_enable,
   input  logic                        req_shift_accumulator,

   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ACC_WIDTH-1:0] rsp_result_value,
   output logic [ACC_INDEX_WIDTH-1:0]  rsp_result_dest,
   output logic                        rsp_overflowed,
   output logic [ACC_COUNT-1:0]        rsp_overflow_flags,

   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]   csr_write_data
);

   csr_type                       csr_ff;
   logic                          stage_valid_ff;
   req_fields_type                stage_ff;
   req_fields_type                stage_in;
   logic [ACC_WIDTH-1:0]          acc_ff [ACC_COUNT];
   logic [ACC_COUNT-1:0]          sticky_ff;
   logic [ACC_COUNT-1:0]          sticky_in;
   logic                          rsp_valid_ff;
   logic signed [ACC_WIDTH-1:0]   result_value_ff;
   logic [ACC_WIDTH-1:0]          result_value_in;
   logic [ACC_INDEX_WIDTH-1:0]    result_dest_ff;
   logic                          overflowed_ff;
   logic                          overflowed_in;

   logic                          advance;
   logic                          req_take;
   logic signed [MUL_WIDTH-1:0]   x_value;
   logic signed [MUL_WIDTH-1:0]   y_value;
   logic signed [PRODUCT_WIDTH-1:0] product;
   logic signed [SUM_WIDTH-1:0]   scaled;
   logic [ACC_WIDTH-1:0]          acc_read;
   logic signed [SUM_WIDTH-1:0]   acc_term;
   logic signed [SUM_WIDTH-1:0]   sum;
   logic [HALF_SHIFT-1:0]         sum_low;
   logic                          round_add;
   logic signed [SUM_WIDTH-1:0]   round_tmp;
   logic signed [SUM_WIDTH-1:0]   value;
   logic signed [SUM_WIDTH-1:0]   limit_hi;
   logic signed [SUM_WIDTH-1:0]   limit_lo;
   logic                          over_hi;
   logic                          over_lo;

   function automatic logic signed [MUL_WIDTH-1:0] pick_operand(
      input logic [SEL_WIDTH-1:0]     sel,
      input logic [OPERAND_WIDTH-1:0] ext,
      input logic                     uns,
      input logic [ACC_WIDTH-1:0]     acc
   );
      logic signed [MUL_WIDTH-1:0] op;
      if (sel < SEL_WIDTH'(ACC_COUNT)) begin
         if (uns) begin
            op = {1'b0, acc[HALF_SHIFT +: OPERAND_WIDTH]};
         end else begin
            op = acc[HALF_SHIFT +: MUL_WIDTH];
         end
      end else begin
         if (uns) begin
            op = {1'b0, ext};
         end else begin
            op = {ext[OPERAND_WIDTH-1], ext};
         end
      end
      return op;
   endfunction

   assign advance   = stage_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stage_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      stage_in.x_select          = req_x_select;
      stage_in.x_operand         = req_x_operand;
      stage_in.y_select          = req_y_select;
      stage_in.y_operand         = req_y_operand;
      stage_in.acc_select        = req_acc_select;
      stage_in.dest_select       = req_dest_select;
      stage_in.unsigned_x        = req_unsigned_x;
      stage_in.unsigned_y        = req_unsigned_y;
      stage_in.subtract_mode     = req_subtract_mode;
      stage_in.force_wide        = req_force_wide;
      stage_in.round_enable      = req_round_enable;
      stage_in.shift_accumulator = req_shift_accumulator;
   end

   always_comb begin
      x_value = pick_operand(stage_ff.x_select, stage_ff.x_operand, stage_ff.unsigned_x,
                             acc_ff[stage_ff.x_select[ACC_INDEX_WIDTH-1:0]]);
      y_value = pick_operand(stage_ff.y_select, stage_ff.y_operand, stage_ff.unsigned_y,
                             acc_ff[stage_ff.y_select[ACC_INDEX_WIDTH-1:0]]);
      product = x_value * y_value;
      scaled  = SUM_WIDTH'(product);
      if (csr_ff.fractional_mode) begin
         scaled = scaled <<< 1;
      end

      acc_read = acc_ff[stage_ff.acc_select[ACC_INDEX_WIDTH-1:0]];
      if (stage_ff.shift_accumulator) begin
         acc_term = SUM_WIDTH'($signed(acc_read[ACC_WIDTH-1:HALF_SHIFT]));
      end else begin
         acc_term = SUM_WIDTH'($signed(acc_read));
      end

      if (stage_ff.acc_select < SEL_WIDTH'(ACC_COUNT)) begin
         sum = stage_ff.subtract_mode ? scaled - acc_term : scaled + acc_term;
      end else begin
         sum = scaled;
      end

      sum_low   = sum[HALF_SHIFT-1:0];
      round_add = 1'b1;
      if (csr_ff.convergent_round && !csr_ff.legacy_compat) begin
         round_add = (sum_low > ROUND_HALF) || (sum_low == ROUND_HALF && sum[HALF_SHIFT]);
      end
      round_tmp = sum + (round_add ? SUM_WIDTH'(ROUND_HALF) : '0);
      if (stage_ff.round_enable) begin
         value = {round_tmp[SUM_WIDTH-1:HALF_SHIFT], {HALF_SHIFT{1'b0}}};
      end else begin
         value = sum;
      end

      if (stage_ff.force_wide || csr_ff.wide_mode) begin
         limit_hi = LIMIT_HI_WIDE;
         limit_lo = LIMIT_LO_WIDE;
      end else begin
         limit_hi = LIMIT_HI_NARROW;
         limit_lo = LIMIT_LO_NARROW;
      end
      over_hi = value > limit_hi;
      over_lo = value < limit_lo;
      overflowed_in = (csr_ff.overflow_detect || csr_ff.saturate_enable) &&
                      (over_hi || over_lo);

      priority if (csr_ff.saturate_enable && over_hi) begin
         result_value_in = limit_hi[ACC_WIDTH-1:0];
      end else if (csr_ff.saturate_enable && over_lo) begin
         result_value_in = limit_lo[ACC_WIDTH-1:0];
      end else begin
         result_value_in = value[ACC_WIDTH-1:0];
      end

      sticky_in = sticky_ff;
      if (overflowed_in && csr_ff.overflow_detect) begin
         sticky_in[stage_ff.dest_select] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FRACTIONAL_MODE:  csr_ff.fractional_mode  <= csr_write_data[0];
            CSR_CONVERGENT_ROUND: csr_ff.convergent_round <= csr_write_data[0];
            CSR_LEGACY_COMPAT:    csr_ff.legacy_compat    <= csr_write_data[0];
            CSR_OVERFLOW_DETECT:  csr_ff.overflow_detect  <= csr_write_data[0];
            CSR_SATURATE_ENABLE:  csr_ff.saturate_enable  <= csr_write_data[0];
            CSR_WIDE_MODE:        csr_ff.wide_mode        <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stage_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_ff <= stage_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ACC_COUNT; i++) begin
            acc_ff[i] <= '0;
         end
         sticky_ff <= '0;
      end else if (advance) begin
         acc_ff[stage_ff.dest_select] <= result_value_in;
         sticky_ff                    <= sticky_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_value_ff <= $signed(result_value_in);
         result_dest_ff  <= stage_ff.dest_select;
         overflowed_ff   <= overflowed_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_value   = result_value_ff;
   assign rsp_result_dest    = result_dest_ff;
   assign rsp_overflowed     = overflowed_ff;
   assign rsp_overflow_flags = sticky_ff;

endmodule

### sv/dmac_checker.sv
`timescale 1ns / 1ps

module dmac_checker
   import dmac_pkg::*;
(
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [ACC_WIDTH-1:0] rsp_result_value,
   input logic [ACC_INDEX_WIDTH-1:0]  rsp_result_dest,
   input logic                        rsp_overflowed,
   input logic [ACC_COUNT-1:0]        rsp_overflow_flags
);

   logic [ACC_COUNT-1:0] last_flags_ff;
   logic [ACC_COUNT-1:0] dest_mask;
   logic [ACC_COUNT-1:0] new_flags;

   assign dest_mask = ACC_COUNT'(1) << rsp_result_dest;
   assign new_flags = rsp_overflow_flags & ~last_flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_flags_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_flags_ff <= rsp_overflow_flags;
      end
   end

   // Sticky flags never clear between transactions.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_overflow_flags & last_flags_ff) == last_flags_ff))
      else $error("sticky overflow flag cleared");

   // Only the destination flag may rise, and only on an overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((new_flags & ~dest_mask) == '0))
      else $error("overflow flag set for a non-destination accumulator");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((new_flags & dest_mask) != '0)) |-> rsp_overflowed)
      else $error("overflow flag set without overflow");

   assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value) &&
         $stable(rsp_result_dest) && $stable(rsp_overflowed) &&
         $stable(rsp_overflow_flags)))
      else $error("stalled response changed");

endmodule

bind dsp_multiply_accumulate_unit_top dmac_checker u_dmac_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_result_value   (rsp_result_value),
   .rsp_result_dest    (rsp_result_dest),
   .rsp_overflowed     (rsp_overflowed),
   .rsp_overflow_flags (rsp_overflow_flags)
);
